>>> hdl/fcrs_pkg.sv
// ----------------------------------------------------------------------------
// fcrs_pkg
// Shared types, codes, reset values and the control store of the FAT16
// cluster chain read sequencer.
// ----------------------------------------------------------------------------
package fcrs_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_BPS      = 3'd0,
		REG_SPC      = 3'd1,
		REG_RSV      = 3'd2,
		REG_COPIES   = 3'd3,
		REG_SPT      = 3'd4,
		REG_ROOT_ENT = 3'd5
	} cfg_reg_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration reset values
	localparam logic [12:0] RST_BPS      = 13'd512;
	localparam logic [7:0]  RST_SPC      = 8'd4;
	localparam logic [15:0] RST_RSV      = 16'd1;
	localparam logic [7:0]  RST_COPIES   = 8'd2;
	localparam logic [15:0] RST_SPT      = 16'd32;
	localparam logic [15:0] RST_ROOT_ENT = 16'd512;

	localparam logic [15:0] END_MARK = 16'hFFF8;
	localparam logic [19:0] LEN_MAX  = 20'hFFFFF;

	// Request actions
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_ENTRY = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_FETCH = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// Modulo unit: dividend is root_entries * 32, one bit per step
	localparam int MOD_X_W   = 21;
	localparam int MOD_D_W   = 13;
	localparam int MOD_CNT_W = $clog2(MOD_X_W);

	typedef struct packed {
		logic        action;
		logic [15:0] start_cluster;
		logic [31:0] size_bytes;
		logic [15:0] table_entry;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] byte_address;
		logic [19:0] length;
		logic        last;
	} out_item_t;

	// Microcode fields
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_RES_BPS,
		MUL_CPY_SPT,
		MUL_PROD_BPS,
		MUL_SPC_BPS,
		MUL_CLU_BPC
	} mul_sel_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_TABLE,
		OP_ROOT,
		OP_BPC,
		OP_DATA,
		OP_SEG,
		OP_WALK_ON,
		OP_WALK_OFF
	} op_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_DATA,
		EMIT_FETCH,
		EMIT_END
	} emit_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_DIV_BUSY,
		COND_END_MARK,
		COND_DISPATCH
	} cond_t;

	localparam int STEP_W = 4;

	// Control store addresses
	localparam logic [STEP_W-1:0] ST_L0   = 4'd0;
	localparam logic [STEP_W-1:0] ST_L1   = 4'd1;
	localparam logic [STEP_W-1:0] ST_L2   = 4'd2;
	localparam logic [STEP_W-1:0] ST_L3   = 4'd3;
	localparam logic [STEP_W-1:0] ST_L4   = 4'd4;
	localparam logic [STEP_W-1:0] ST_L5   = 4'd5;
	localparam logic [STEP_W-1:0] ST_IDLE = 4'd6;
	localparam logic [STEP_W-1:0] ST_V0   = 4'd7;
	localparam logic [STEP_W-1:0] ST_V1   = 4'd8;
	localparam logic [STEP_W-1:0] ST_V2   = 4'd9;
	localparam logic [STEP_W-1:0] ST_V3   = 4'd10;
	localparam logic [STEP_W-1:0] ST_END  = 4'd11;

	typedef struct packed {
		mul_sel_t          mul;
		op_t               op;
		emit_t             emit;
		logic              div_start;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} uword_t;

	typedef struct packed {
		mul_sel_t mul;
		op_t      op;
		emit_t    emit;
		logic     div_start;
		logic     load_start;
		logic     load_entry;
	} ctrl_t;

	typedef struct packed {
		logic end_mark;
		logic div_busy;
		logic out_free;
		logic walking;
	} stat_t;

	// Control store
	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		case (step)
			ST_L0:   w = '{MUL_RES_BPS,  OP_NONE,     EMIT_NONE,  1'b1, COND_NEXT,     ST_L0};
			ST_L1:   w = '{MUL_CPY_SPT,  OP_TABLE,    EMIT_NONE,  1'b0, COND_NEXT,     ST_L0};
			ST_L2:   w = '{MUL_PROD_BPS, OP_NONE,     EMIT_NONE,  1'b0, COND_NEXT,     ST_L0};
			ST_L3:   w = '{MUL_SPC_BPS,  OP_ROOT,     EMIT_NONE,  1'b0, COND_NEXT,     ST_L0};
			ST_L4:   w = '{MUL_NONE,     OP_BPC,      EMIT_NONE,  1'b0, COND_DIV_BUSY, ST_L4};
			ST_L5:   w = '{MUL_NONE,     OP_DATA,     EMIT_NONE,  1'b0, COND_ALWAYS,   ST_IDLE};
			ST_IDLE: w = '{MUL_NONE,     OP_NONE,     EMIT_NONE,  1'b0, COND_DISPATCH, ST_V0};
			ST_V0:   w = '{MUL_CLU_BPC,  OP_NONE,     EMIT_NONE,  1'b0, COND_END_MARK, ST_END};
			ST_V1:   w = '{MUL_NONE,     OP_SEG,      EMIT_NONE,  1'b0, COND_NEXT,     ST_L0};
			ST_V2:   w = '{MUL_NONE,     OP_NONE,     EMIT_DATA,  1'b0, COND_NEXT,     ST_L0};
			ST_V3:   w = '{MUL_NONE,     OP_WALK_ON,  EMIT_FETCH, 1'b0, COND_ALWAYS,   ST_IDLE};
			ST_END:  w = '{MUL_NONE,     OP_WALK_OFF, EMIT_END,   1'b0, COND_ALWAYS,   ST_IDLE};
			default: w = '{MUL_NONE,     OP_NONE,     EMIT_NONE,  1'b0, COND_ALWAYS,   ST_L0};
		endcase
		return w;
	endfunction

endpackage

>>> hdl/fcrs_mod.sv
// ----------------------------------------------------------------------------
// fcrs_mod
// Restoring remainder unit, one dividend bit per clock.
// ----------------------------------------------------------------------------
module fcrs_mod (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [fcrs_pkg::MOD_X_W-1:0]   dividend,
	input  logic [fcrs_pkg::MOD_D_W-1:0]   divisor,
	output logic                           busy,
	output logic [fcrs_pkg::MOD_D_W-1:0]   remainder
);

	logic                             busy_q;
	logic [fcrs_pkg::MOD_CNT_W-1:0]   cnt_q;
	logic [fcrs_pkg::MOD_X_W-1:0]     x_q;
	logic [fcrs_pkg::MOD_D_W-1:0]     r_q;
	logic [fcrs_pkg::MOD_D_W:0]       trial;
	logic [fcrs_pkg::MOD_D_W:0]       diff;

	assign trial = {r_q, x_q[fcrs_pkg::MOD_X_W-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= fcrs_pkg::MOD_CNT_W'(fcrs_pkg::MOD_X_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= dividend;
			r_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[fcrs_pkg::MOD_X_W-2:0], 1'b0};
			// subtract only when the trial value reaches the divisor
			if (trial >= {1'b0, divisor}) begin
				r_q <= diff[fcrs_pkg::MOD_D_W-1:0];
			end else begin
				r_q <= trial[fcrs_pkg::MOD_D_W-1:0];
			end
		end
	end

	assign busy      = busy_q;
	assign remainder = r_q;

endmodule

>>> hdl/fcrs_dpath.sv
// ----------------------------------------------------------------------------
// fcrs_dpath
// Datapath: configuration registers, shared multiplier, layout and walk
// registers, and the output register.
// ----------------------------------------------------------------------------
module fcrs_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fcrs_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [fcrs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  fcrs_pkg::in_item_t                in_data,
	input  fcrs_pkg::ctrl_t                   ctrl,
	output fcrs_pkg::stat_t                   stat,
	output logic                              out_valid,
	input  logic                              out_stall,
	output fcrs_pkg::out_item_t               out_data
);

	// Configuration
	logic [12:0] bps_q;
	logic [7:0]  spc_q;
	logic [15:0] rsv_q;
	logic [7:0]  cpy_q;
	logic [15:0] spt_q;
	logic [15:0] ren_q;

	// Layout and walk
	logic [31:0] prod_q;
	logic [31:0] tstart_q;
	logic [31:0] rstart_q;
	logic [31:0] dstart_q;
	logic [20:0] bpc_q;
	logic [15:0] cur_q;
	logic [31:0] rem_q;
	logic [31:0] addr_q;
	logic [19:0] len_q;
	logic        walking_q;

	logic                 out_valid_q;
	fcrs_pkg::out_item_t  out_q;

	logic [23:0] mul_a;
	logic [20:0] mul_b;
	logic [44:0] mul_full;
	logic        mul_en;

	logic                             div_busy;
	logic [fcrs_pkg::MOD_D_W-1:0]     div_rem;
	logic [fcrs_pkg::MOD_X_W-1:0]     dir_bytes;
	logic [21:0]                      root_span;
	logic [19:0]                      bpc_len;
	logic [19:0]                      seg_len;
	logic                             out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bps_q <= fcrs_pkg::RST_BPS;
			spc_q <= fcrs_pkg::RST_SPC;
			rsv_q <= fcrs_pkg::RST_RSV;
			cpy_q <= fcrs_pkg::RST_COPIES;
			spt_q <= fcrs_pkg::RST_SPT;
			ren_q <= fcrs_pkg::RST_ROOT_ENT;
		end else if (cfg_we) begin
			case (cfg_idx)
				fcrs_pkg::REG_BPS:      bps_q <= cfg_wdata[12:0];
				fcrs_pkg::REG_SPC:      spc_q <= cfg_wdata[7:0];
				fcrs_pkg::REG_RSV:      rsv_q <= cfg_wdata;
				fcrs_pkg::REG_COPIES:   cpy_q <= cfg_wdata[7:0];
				fcrs_pkg::REG_SPT:      spt_q <= cfg_wdata;
				fcrs_pkg::REG_ROOT_ENT: ren_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Root directory span: root bytes rounded up to whole sectors
	assign dir_bytes = {ren_q, 5'b0};

	fcrs_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctrl.div_start),
		.dividend  (dir_bytes),
		.divisor   (bps_q),
		.busy      (div_busy),
		.remainder (div_rem)
	);

	always_comb begin
		if (bps_q == '0) begin
			root_span = '0;
		end else if (div_rem == '0) begin
			root_span = {1'b0, dir_bytes};
		end else begin
			root_span = {1'b0, dir_bytes} + {9'b0, bps_q} - {9'b0, div_rem};
		end
	end

	// Shared multiplier
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (ctrl.mul)
			fcrs_pkg::MUL_RES_BPS: begin
				mul_a = {8'b0, rsv_q};
				mul_b = {8'b0, bps_q};
			end
			fcrs_pkg::MUL_CPY_SPT: begin
				mul_a = {16'b0, cpy_q};
				mul_b = {5'b0, spt_q};
			end
			fcrs_pkg::MUL_PROD_BPS: begin
				mul_a = prod_q[23:0];
				mul_b = {8'b0, bps_q};
			end
			fcrs_pkg::MUL_SPC_BPS: begin
				mul_a = {16'b0, spc_q};
				mul_b = {8'b0, bps_q};
			end
			fcrs_pkg::MUL_CLU_BPC: begin
				mul_a = {8'b0, cur_q};
				mul_b = bpc_q;
			end
			default: mul_en = 1'b0;
		endcase
	end

	assign mul_full = 45'(mul_a) * 45'(mul_b);

	// Segment length: cluster bytes clamped to the length field, then to what is left
	assign bpc_len = (bpc_q > {1'b0, fcrs_pkg::LEN_MAX}) ? fcrs_pkg::LEN_MAX : bpc_q[19:0];
	assign seg_len = (rem_q < {12'b0, bpc_len}) ? rem_q[19:0] : bpc_len;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_full[31:0];
		end
		if (ctrl.load_start) begin
			cur_q <= in_data.start_cluster;
			rem_q <= in_data.size_bytes;
		end else if (ctrl.load_entry) begin
			cur_q <= in_data.table_entry;
		end
		case (ctrl.op)
			fcrs_pkg::OP_TABLE: tstart_q <= prod_q;
			fcrs_pkg::OP_ROOT:  rstart_q <= tstart_q + prod_q;
			fcrs_pkg::OP_BPC:   bpc_q    <= prod_q[20:0];
			fcrs_pkg::OP_DATA:  dstart_q <= rstart_q + {10'b0, root_span};
			fcrs_pkg::OP_SEG: begin
				if (cur_q == '0) begin
					addr_q <= rstart_q;
				end else begin
					// cluster minus two, wrapping for cluster one
					addr_q <= dstart_q + prod_q - {10'b0, bpc_q, 1'b0};
				end
				len_q <= seg_len;
				rem_q <= rem_q - {12'b0, seg_len};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walking_q <= 1'b0;
		end else if (ctrl.op == fcrs_pkg::OP_WALK_ON) begin
			walking_q <= 1'b1;
		end else if (ctrl.op == fcrs_pkg::OP_WALK_OFF) begin
			walking_q <= 1'b0;
		end
	end

	// Output register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit != fcrs_pkg::EMIT_NONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			case (ctrl.emit)
				fcrs_pkg::EMIT_DATA: begin
					out_q.kind         <= fcrs_pkg::KIND_DATA;
					out_q.byte_address <= addr_q;
					out_q.length       <= len_q;
					out_q.last         <= 1'b0;
				end
				fcrs_pkg::EMIT_FETCH: begin
					out_q.kind         <= fcrs_pkg::KIND_FETCH;
					out_q.byte_address <= tstart_q + {15'b0, cur_q, 1'b0};
					out_q.length       <= '0;
					out_q.last         <= 1'b1;
				end
				fcrs_pkg::EMIT_END: begin
					out_q.kind         <= fcrs_pkg::KIND_END;
					out_q.byte_address <= '0;
					out_q.length       <= '0;
					out_q.last         <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign stat.end_mark = (cur_q >= fcrs_pkg::END_MARK);
	assign stat.div_busy = div_busy;
	assign stat.out_free = out_free;
	assign stat.walking  = walking_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> hdl/fcrs_useq.sv
// ----------------------------------------------------------------------------
// fcrs_useq
// Microcode sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
module fcrs_useq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 in_valid,
	input  logic                 in_action,
	input  fcrs_pkg::stat_t      stat,
	output logic                 in_stall,
	output fcrs_pkg::ctrl_t      ctrl
);

	logic [fcrs_pkg::STEP_W-1:0] step_q;
	logic [fcrs_pkg::STEP_W-1:0] step_nxt;
	fcrs_pkg::uword_t            uw;
	logic                        accept;
	logic                        go;
	logic                        hold;

	assign uw = fcrs_pkg::ucode(step_q);

	// Take requests only at the dispatch step and never alongside a register write
	assign in_stall = (step_q != fcrs_pkg::ST_IDLE) || cfg_we;
	assign accept   = in_valid && !in_stall;
	// A table entry while no chain is open is dropped
	assign go       = accept && (in_action == fcrs_pkg::ACT_START || stat.walking);
	assign hold     = (uw.emit != fcrs_pkg::EMIT_NONE) && !stat.out_free;

	always_comb begin
		step_nxt = step_q + 1'b1;
		case (uw.cond)
			fcrs_pkg::COND_NEXT:     step_nxt = hold ? step_q : step_q + 1'b1;
			fcrs_pkg::COND_ALWAYS:   step_nxt = hold ? step_q : uw.target;
			fcrs_pkg::COND_DIV_BUSY: step_nxt = stat.div_busy ? uw.target : step_q + 1'b1;
			fcrs_pkg::COND_END_MARK: step_nxt = stat.end_mark ? uw.target : step_q + 1'b1;
			fcrs_pkg::COND_DISPATCH: step_nxt = go ? uw.target : step_q;
			default:                 step_nxt = fcrs_pkg::ST_L0;
		endcase
		if (cfg_we) begin
			step_nxt = fcrs_pkg::ST_L0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= fcrs_pkg::ST_L0;
		end else begin
			step_q <= step_nxt;
		end
	end

	assign ctrl.mul        = uw.mul;
	assign ctrl.op         = uw.op;
	assign ctrl.emit       = uw.emit;
	assign ctrl.div_start  = uw.div_start;
	assign ctrl.load_start = accept && (in_action == fcrs_pkg::ACT_START);
	assign ctrl.load_entry = accept && (in_action == fcrs_pkg::ACT_ENTRY) && stat.walking;

endmodule

>>> hdl/fat16_file_cluster_read_sequencer_top.sv
// ----------------------------------------------------------------------------
// fat16_file_cluster_read_sequencer_top
// Follows a FAT16 cluster chain and issues the data and table reads of a file.
// ----------------------------------------------------------------------------
// Usage:
//  - The register port (cfg_we, cfg_idx, cfg_wdata) holds the volume layout.
//    Every write restarts the layout program, which waits on the
//    21-step remainder unit; in_stall stays high until it ends.
//  - Input requests (in_valid/in_stall/in_data) either start a file read or
//    return a table entry. A start always restarts the walk; an entry while
//    no chain is open is dropped with no result.
//  - Each cluster below the end marker yields a data segment request, then a
//    table entry fetch marked last. An end marker yields one chain-ended
//    result marked last.
//  - Order: after acceptance the program steps V0, V1 (segment address and
//    length), V2 (data segment) and V3 (fetch); an end marker goes to the
//    end step. Requests are handled one at a time by the microcode program;
//    the next one is taken at the dispatch step.
//  - When out_stall is high the output register holds its request and the
//    program waits on its emit step; nothing is lost or repeated.
//  - Reset clears the walk state, loads the default layout registers and
//    runs the layout program before the first request is taken.
// ----------------------------------------------------------------------------
module fat16_file_cluster_read_sequencer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fcrs_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [fcrs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  fcrs_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output fcrs_pkg::out_item_t               out_data
);

	fcrs_pkg::ctrl_t ctrl;
	fcrs_pkg::stat_t stat;

	// Control: step counter walking the control store
	fcrs_useq u_useq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.in_valid  (in_valid),
		.in_action (in_data.action),
		.stat      (stat),
		.in_stall  (in_stall),
		.ctrl      (ctrl)
	);

	// Datapath: layout registers, shared multiplier, output register
	fcrs_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.ctrl      (ctrl),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

>>> tb/tb_fat16_file_cluster_read_sequencer_top.sv
// ----------------------------------------------------------------------------
// tb_fat16_file_cluster_read_sequencer_top
// Self-checking bench for the FAT16 cluster chain read sequencer. Chains of
// start and table-entry requests are sent through a valid/stall driver under
// several volume layouts. A behavioural walk of the chain predicts every data
// segment, table fetch and chain-end result, and a monitor compares each one
// field by field.
// ----------------------------------------------------------------------------
module tb_fat16_file_cluster_read_sequencer_top;

	import fcrs_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int PHASE_ITEMS  = 200;
	localparam int SETTLE_WAIT  = 12;
	localparam int MAX_REPORTS  = 100;

	// Clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Block ports
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;

	fat16_file_cluster_read_sequencer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// Layout registers as the block should hold them
	logic [12:0] sector_bytes;
	logic [7:0]  cluster_sectors;
	logic [15:0] reserved_cnt;
	logic [7:0]  copies_cnt;
	logic [15:0] table_sectors;
	logic [15:0] root_dir_entries;

	// Derived byte offsets and the walk state
	logic [31:0] table_base;
	logic [31:0] root_base;
	logic [31:0] data_base;
	logic [31:0] bytes_left;
	logic        chain_open;

	in_item_t  pending_requests[$];
	out_item_t expected_reads[$];
	out_item_t want_read;

	int reqs_queued  = 0;
	int reqs_taken   = 0;
	int chain_items  = 0;
	int fault_count  = 0;
	int quiet_cycles = 0;
	int send_hold    = 0;
	int stall_hold   = 0;
	bit send_idling  = 1'b1;
	bit recv_idling  = 1'b1;

	// ------------------------------------------------------------------
	// Chain walk prediction
	// ------------------------------------------------------------------

	// Recompute the three region offsets; everything wraps at 32 bits.
	function automatic void recompute_layout();
		logic [63:0] sec;
		logic [63:0] root_secs;
		sec        = 64'(sector_bytes);
		table_base = 32'(64'(reserved_cnt) * sec);
		root_base  = 32'(64'(table_base) + 64'(copies_cnt) * 64'(table_sectors) * sec);
		// A zero sector size leaves the root directory with no sectors
		root_secs  = (sec == 64'd0) ? 64'd0 :
			(64'(root_dir_entries) * 64'd32 + sec - 64'd1) / sec;
		data_base  = 32'(64'(root_base) + root_secs * sec);
	endfunction

	// Visit one cluster: segment plus fetch, or the chain-end result.
	function automatic void visit_cluster(logic [15:0] cluster);
		logic [31:0] bpc_full;
		logic [31:0] bpc_len;
		logic [31:0] seg_addr;
		logic [31:0] seg_len;
		out_item_t   res;
		if (cluster >= END_MARK) begin
			chain_open = 1'b0;
			res = '{kind: KIND_END, byte_address: 32'd0, length: 20'd0, last: 1'b1};
			expected_reads.insert(expected_reads.size(), res);
			return;
		end
		chain_open = 1'b1;
		bpc_full   = 32'(cluster_sectors) * 32'(sector_bytes);
		// Oversized clusters clamp the length only, not the address step
		bpc_len    = (bpc_full > 32'(LEN_MAX)) ? 32'(LEN_MAX) : bpc_full;
		// Cluster zero reads the root directory; cluster one wraps below data
		seg_addr   = (cluster == 16'd0) ? root_base :
			data_base + (32'(cluster) - 32'd2) * bpc_full;
		seg_len    = (bytes_left < bpc_len) ? bytes_left : bpc_len;
		bytes_left = bytes_left - seg_len;
		res = '{kind: KIND_DATA, byte_address: seg_addr, length: seg_len[19:0], last: 1'b0};
		expected_reads.insert(expected_reads.size(), res);
		res = '{kind: KIND_FETCH, byte_address: table_base + 32'(cluster) * 32'd2,
			length: 20'd0, last: 1'b1};
		expected_reads.insert(expected_reads.size(), res);
	endfunction

	// Predict the results of one accepted request.
	function automatic void take_request(in_item_t req);
		if (req.action == ACT_START) begin
			bytes_left = req.size_bytes;
			visit_cluster(req.start_cluster);
		end else if (chain_open) begin
			visit_cluster(req.table_entry);
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	task automatic report_fault(input string msg);
		if (fault_count < MAX_REPORTS)
			$display("%0t: %s", $time, msg);
		fault_count++;
	endtask

	function automatic void queue_request(logic act, logic [15:0] clu, logic [31:0] size,
			logic [15:0] entry);
		in_item_t req;
		req = '{action: act, start_cluster: clu, size_bytes: size, table_entry: entry};
		pending_requests.insert(pending_requests.size(), req);
		reqs_queued++;
	endfunction

	function automatic logic [15:0] pick_cluster();
		case ($urandom_range(0, 7))
			0:       return 16'd0;
			1:       return 16'd1;
			2:       return 16'd2;
			3:       return END_MARK - 16'd1;
			default: return 16'($urandom_range(2, 32'(END_MARK) - 1));
		endcase
	endfunction

	function automatic logic [15:0] pick_end_mark();
		return 16'($urandom_range(32'(END_MARK), 32'hFFFF));
	endfunction

	// Queue one chain: a start, a few entries, then mostly an end marker.
	// Chains left open are restarted by the next start; a stray entry after
	// the end is dropped by the block and not counted.
	function automatic void queue_chain();
		logic [31:0] bpc;
		logic [31:0] size;
		logic [15:0] first;
		int          hops;
		int          tail;
		bpc = 32'(cluster_sectors) * 32'(sector_bytes);
		case ($urandom_range(0, 5))
			0:       size = 32'd0;
			1:       size = $urandom;
			2:       size = 32'hFFFF_FFFF;
			3:       size = bpc * 32'($urandom_range(1, 4));
			default: size = $urandom_range(0, bpc * 6);
		endcase
		first = ($urandom_range(0, 19) == 0) ? pick_end_mark() : pick_cluster();
		queue_request(ACT_START, first, size, 16'($urandom));
		chain_items++;
		if (first >= END_MARK)
			return;
		hops = $urandom_range(0, 8);
		repeat (hops)
			queue_request(ACT_ENTRY, 16'($urandom), $urandom, pick_cluster());
		chain_items += hops;
		tail = $urandom_range(0, 9);
		if (tail >= 2) begin
			queue_request(ACT_ENTRY, 16'($urandom), $urandom, pick_end_mark());
			chain_items++;
			if (tail == 9)
				queue_request(ACT_ENTRY, 16'($urandom), $urandom, pick_cluster());
		end
	endfunction

	// Wait until every request is taken and every result has come, then let
	// the block finish any request that produces nothing.
	task automatic settle();
		while (reqs_taken != reqs_queued)
			@(posedge clk);
		while (expected_reads.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_BPS:      sector_bytes     = val[12:0];
			REG_SPC:      cluster_sectors  = val[7:0];
			REG_RSV:      reserved_cnt     = val;
			REG_COPIES:   copies_cnt       = val[7:0];
			REG_SPT:      table_sectors    = val;
			REG_ROOT_ENT: root_dir_entries = val;
			default: ;
		endcase
		recompute_layout();
	endtask

	task automatic program_layout(input logic [15:0] bps, input logic [15:0] spc,
			input logic [15:0] rsv, input logic [15:0] copies, input logic [15:0] spt,
			input logic [15:0] roots);
		write_reg(REG_BPS, bps);
		write_reg(REG_SPC, spc);
		write_reg(REG_RSV, rsv);
		write_reg(REG_COPIES, copies);
		write_reg(REG_SPT, spt);
		write_reg(REG_ROOT_ENT, roots);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Request driver: present queued requests, hold while stalled, and
	// drop valid for a random burst now and then.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			in_data   <= '0;
			send_hold <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				take_request(in_data);
				reqs_taken++;
			end
			// A stalled request stays as it is
			if (!(in_valid && in_stall)) begin
				if (send_hold > 0) begin
					in_valid  <= 1'b0;
					send_hold <= send_hold - 1;
				end else if (pending_requests.size() != 0) begin
					in_valid <= 1'b1;
					in_data  <= pending_requests.pop_front();
					if (send_idling && $urandom_range(0, 5) == 0)
						send_hold <= $urandom_range(1, 15);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: check each accepted result against the oldest
	// prediction, and stall the output in random bursts.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_hold <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_reads.size() == 0) begin
					report_fault($sformatf("result with nothing outstanding: kind %0d addr %h",
						out_data.kind, out_data.byte_address));
				end else begin
					want_read = expected_reads.pop_front();
					if (out_data.kind !== want_read.kind)
						report_fault($sformatf("kind mismatch: got %0d want %0d",
							out_data.kind, want_read.kind));
					if (out_data.byte_address !== want_read.byte_address)
						report_fault($sformatf("address mismatch: got %h want %h",
							out_data.byte_address, want_read.byte_address));
					if (out_data.length !== want_read.length)
						report_fault($sformatf("length mismatch: got %h want %h",
							out_data.length, want_read.length));
					if (out_data.last !== want_read.last)
						report_fault($sformatf("last mismatch: got %b want %b",
							out_data.last, want_read.last));
				end
			end
			if (stall_hold > 0) begin
				out_stall  <= 1'b1;
				stall_hold <= stall_hold - 1;
			end else begin
				out_stall <= 1'b0;
				if (recv_idling && $urandom_range(0, 7) == 0)
					stall_hold <= $urandom_range(1, 15);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run if nothing moves for too long
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		// Layout and walk state after reset
		sector_bytes     = RST_BPS;
		cluster_sectors  = RST_SPC;
		reserved_cnt     = RST_RSV;
		copies_cnt       = RST_COPIES;
		table_sectors    = RST_SPT;
		root_dir_entries = RST_ROOT_ENT;
		bytes_left       = 32'd0;
		chain_open       = 1'b0;
		recompute_layout();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests under the reset layout.
		// Empty file: the first segment already has zero length
		queue_request(ACT_START, 16'd2, 32'd0, 16'd0);
		queue_request(ACT_ENTRY, 16'd0, 32'd0, 16'd3);
		queue_request(ACT_ENTRY, 16'd0, 32'd0, 16'hFFFF);
		// Entry with no chain open: dropped
		queue_request(ACT_ENTRY, 16'd0, 32'd0, 16'd5);
		// Root directory cluster, then cluster one, the top valid cluster and the end
		queue_request(ACT_START, 16'd0, 32'hFFFF_FFFF, 16'd0);
		queue_request(ACT_ENTRY, 16'd0, 32'd0, 16'd1);
		queue_request(ACT_ENTRY, 16'd0, 32'd0, END_MARK - 16'd1);
		queue_request(ACT_ENTRY, 16'd0, 32'd0, END_MARK);
		// Start straight on an end marker, lowest and highest
		queue_request(ACT_START, END_MARK, 32'h1234_5678, 16'd0);
		queue_request(ACT_START, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		// Restart in the middle of a chain
		queue_request(ACT_START, 16'd100, 32'd5000, 16'd0);
		queue_request(ACT_ENTRY, 16'd0, 32'd0, 16'd101);
		queue_request(ACT_START, 16'd7, 32'd1, 16'd0);
		queue_request(ACT_ENTRY, 16'd0, 32'd0, 16'd8);
		queue_request(ACT_ENTRY, 16'd0, 32'd0, 16'hFFF9);
		// File of exactly one cluster: later segments run dry
		queue_request(ACT_START, 16'd2, 32'd2048, 16'd0);
		queue_request(ACT_ENTRY, 16'd0, 32'd0, 16'd3);
		queue_request(ACT_ENTRY, 16'hFFFF, 32'hFFFF_FFFF, 16'hAAAA);
		queue_request(ACT_ENTRY, 16'd0, 32'd0, 16'h5555);
		queue_request(ACT_ENTRY, 16'd0, 32'd0, 16'hFFFC);
		// Hold the sender until every result has come
		settle();

		// Random chains, one layout per phase; the last phase runs flat out
		for (int phase = 0; phase < 9; phase++) begin
			case (phase)
				0: program_layout(16'd512, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
				1: program_layout(16'd4096, 16'd128, 16'hFFFF, 16'd255, 16'hFFFF, 16'hFFFF);
				// Zero sector size
				2: program_layout(16'd0, 16'd128, 16'd7, 16'd2, 16'd300, 16'd513);
				// Oversized cluster, with the unused upper bits of the words set
				3: program_layout(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				4: program_layout(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom));
				5: program_layout(16'(RST_BPS), 16'(RST_SPC), RST_RSV, 16'(RST_COPIES),
					RST_SPT, RST_ROOT_ENT);
				default: program_layout(16'($urandom_range(512, 4096)),
					16'($urandom_range(1, 128)), 16'($urandom_range(1, 65535)),
					16'($urandom_range(1, 255)), 16'($urandom_range(1, 65535)),
					16'($urandom));
			endcase
			send_idling = !(phase == 3 || phase == 8);
			recv_idling = !(phase == 5 || phase == 8);
			chain_items = 0;
			while (chain_items < PHASE_ITEMS)
				queue_chain();
			settle();
		end

		if (fault_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
